@@ rtl/insertion_sorter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// insertion sorter assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// same-cycle implication
`define ISU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion sorter check failed");

// next-cycle implication
`define ISU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion sorter check failed");

`endif

@@ rtl/isu_pkg.sv @@
// ----------------------------------------------------------------------------
// isu_pkg
// shared types and widths of the insertion sorter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isu_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic  insert;
        logic  unload;
        t_data value;
    } t_cell_ctl;

    // what one cell shows its neighbors
    typedef struct packed {
        logic  valid;
        logic  gt;
        t_data data;
    } t_cell_link;

endpackage

@@ rtl/isu_stream_if.sv @@
// ----------------------------------------------------------------------------
// isu stream interfaces
// valid/ready channels for input values and sorted results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isu_in_if import isu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isu_out_if import isu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data sorted_value;
    logic  final_res;
    logic  overflow;

    modport source (output valid, output sorted_value, output final_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input overflow, output ready);
endinterface

@@ rtl/isu_cell.sv @@
// ----------------------------------------------------------------------------
// isu_cell
// one slot of the sorting chain: compares, shifts up on insert, down on unload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isu_cell import isu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_link i_lo,
    input  t_cell_link i_hi,
    output t_cell_link o_link
);

    logic  r_valid;
    logic  n_valid;
    t_data r_data;
    t_data n_data;
    logic  gt;

    assign gt = r_valid && (r_data > i_ctl.value);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.insert) begin
            // larger entries move up, first free slot takes its place
            if (gt || (!r_valid && i_lo.valid)) begin
                n_valid = 1'b1;
                n_data  = i_lo.gt ? i_lo.data : i_ctl.value;
            end
        end else if (i_ctl.unload) begin
            n_valid = i_hi.valid;
            n_data  = i_hi.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = gt;
    assign o_link.data  = r_data;

endmodule

@@ rtl/insertion_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// online insertion sort of signed values in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// Values enter one per cycle while a set is being collected: every cell
// compares its entry with the new value in the same cycle, larger entries
// move up one cell and the value drops into the freed slot, so equal values
// keep arrival order. The transfer flagged last closes the set; from the next
// cycle the chain unloads through cell 0, one result per cycle while the sink
// is ready, and input is held off until the final result is taken. Values
// beyond DEPTH are dropped and every result of that set carries overflow.
`timescale 1ns / 1ps

module insertion_sorter_unit import isu_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    isu_in_if.sink     i_in,
    isu_out_if.source  o_out
);

    `include "insertion_sorter_unit_assert.svh"

    logic       r_draining;
    logic       n_draining;
    logic       r_dropped;
    logic       n_dropped;
    logic       in_xfer;
    logic       out_xfer;
    logic       full;
    t_cell_ctl  ctl;
    t_cell_link link [DEPTH];
    t_cell_link lo_end;
    t_cell_link hi_end;

    assign full     = link[DEPTH-1].valid;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    assign ctl.insert = in_xfer && !full;
    assign ctl.unload = out_xfer;
    assign ctl.value  = i_in.value;

    assign lo_end = '{valid: 1'b1, gt: 1'b0, data: '0};
    assign hi_end = '{valid: 1'b0, gt: 1'b0, data: '0};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        isu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_lo    ((g == 0) ? lo_end : link[(g == 0) ? 0 : g - 1]),
            .i_hi    ((g == DEPTH - 1) ? hi_end : link[(g == DEPTH - 1) ? g : g + 1]),
            .o_link  (link[g])
        );
    end

    always_comb begin
        n_draining = r_draining;
        n_dropped  = r_dropped;
        if (in_xfer) begin
            n_dropped = r_dropped | full;
            if (i_in.last) begin
                n_draining = 1'b1;
            end
        end
        if (out_xfer && o_out.final_res) begin
            n_draining = 1'b0;
            n_dropped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            r_draining <= n_draining;
            r_dropped  <= n_dropped;
        end
    end

    assign i_in.ready         = !r_draining;
    assign o_out.valid        = r_draining;
    assign o_out.sorted_value = link[0].data;
    assign o_out.final_res    = !link[1].valid;
    assign o_out.overflow     = r_dropped;

    // unload always has an entry in the bottom cell
    `ISU_ASSERT_IMPLY(a_drain_has_data, i_clk, i_rst_n, r_draining, link[0].valid)
    // the closing transfer starts unload
    `ISU_ASSERT_NEXT(a_last_starts_drain, i_clk, i_rst_n, in_xfer && i_in.last, r_draining)
    // chain is empty after the final result
    `ISU_ASSERT_NEXT(a_final_empties, i_clk, i_rst_n, out_xfer && o_out.final_res,
                     !r_draining && !link[0].valid && !r_dropped)

endmodule
